// ===== rtl/core/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants of the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // A BCD digit at or above this value gets +3 before the next shift
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;         // capture a new value
    logic shift_bit;    // one double-dabble step
    logic shift_digit;  // drop a leading zero digit
    logic emit_sign;    // load '-' into the output register
    logic emit_digit;   // load the top digit into the output register
  } cmd_t;

  typedef struct packed {
    logic bits_last;    // final conversion step is under way
    logic top_zero;     // leading BCD digit is zero
    logic one_left;     // one digit remains
    logic neg;          // value is negative
    logic out_free;     // output register can take a character
  } sts_t;

endpackage

// ===== rtl/core/sida_in_if.sv =====
// ----------------------------------------------------------------------------
// sida_in_if
// Input channel: one signed integer per transfer.
// ----------------------------------------------------------------------------
interface sida_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/sida_out_if.sv =====
// ----------------------------------------------------------------------------
// sida_out_if
// Result channel: one ASCII character per transfer, with a last flag.
// ----------------------------------------------------------------------------
interface sida_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ===== rtl/core/sida_ctrl.sv =====
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer: capture, bit-serial conversion, zero suppression, emission.
// ----------------------------------------------------------------------------
module sida_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sida_pkg::sts_t  sts,
  output sida_pkg::cmd_t  cmd
);

  sida_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sida_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sida_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sida_pkg::ST_CONV;
        end
      end
      sida_pkg::ST_CONV: begin
        cmd.shift_bit = 1'b1;
        if (sts.bits_last) state_nxt = sida_pkg::ST_SKIP;
      end
      sida_pkg::ST_SKIP: begin
        if (sts.top_zero && !sts.one_left) begin
          cmd.shift_digit = 1'b1;
        end else if (sts.neg) begin
          state_nxt = sida_pkg::ST_SIGN;
        end else begin
          state_nxt = sida_pkg::ST_EMIT;
        end
      end
      sida_pkg::ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = sida_pkg::ST_EMIT;
        end
      end
      sida_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.one_left) state_nxt = sida_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sida_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sida_dp.sv =====
// ----------------------------------------------------------------------------
// sida_dp
// Datapath: magnitude shifter, BCD double-dabble register, output register.
// ----------------------------------------------------------------------------
module sida_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          out_ready,
  input  sida_pkg::cmd_t                cmd,
  output sida_pkg::sts_t                sts,
  output logic                          out_valid,
  output logic [6:0]                    out_ascii_char,
  output logic                          out_last
);

  // Decimal digits needed for 2^(VALUE_WIDTH-1), with margin
  localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCDW  = 4 * NDIG;
  localparam int BCW   = $clog2(VALUE_WIDTH);
  localparam int DCW   = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCDW-1:0]        bcd_r, bcd_nxt, bcd_adj;
  logic                   neg_r, neg_nxt;
  logic [BCW-1:0]         bitcnt_r, bitcnt_nxt;
  logic [DCW-1:0]         dcnt_r, dcnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [6:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [VALUE_WIDTH-1:0] vin;
  logic [3:0]             top_dig;

  assign vin     = in_value;
  assign top_dig = bcd_r[BCDW-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= sida_pkg::BCD_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + sida_pkg::BCD_ADJ_ADD;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    bitcnt_nxt    = bitcnt_r;
    dcnt_nxt      = dcnt_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      neg_nxt    = vin[VALUE_WIDTH-1];
      mag_nxt    = vin[VALUE_WIDTH-1] ? (~vin + 1'b1) : vin;
      bcd_nxt    = '0;
      bitcnt_nxt = '0;
      dcnt_nxt   = DCW'(NDIG);
    end
    if (cmd.shift_bit) begin
      bcd_nxt    = {bcd_adj[BCDW-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt    = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bitcnt_nxt = bitcnt_r + 1'b1;
    end
    if (cmd.shift_digit || cmd.emit_digit) begin
      bcd_nxt  = {bcd_r[BCDW-5:0], 4'd0};
      dcnt_nxt = dcnt_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = sida_pkg::CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = sida_pkg::CHAR_ZERO + {3'd0, top_dig};
      out_last_nxt  = (dcnt_r == DCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    bitcnt_r   <= bitcnt_nxt;
    dcnt_r     <= dcnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.bits_last = (bitcnt_r == BCW'(VALUE_WIDTH - 1));
  assign sts.top_zero  = (top_dig == 4'd0);
  assign sts.one_left  = (dcnt_r == DCW'(1));
  assign sts.neg       = neg_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// Converts one signed two's-complement integer per input transfer into its
// decimal ASCII text, most significant character first: an optional '-',
// then the digits without leading zeros ('0' for zero), the final character
// flagged with last. The most negative value converts exactly. One number is
// in work at a time. Each item is captured, then converted by bit-serial
// binary-to-BCD conversion over all VALUE_WIDTH bits (one double-dabble
// step a cycle); leading zero digits are then dropped one by one, and the
// characters go out one at a time through the output register, the only
// limit on emission. Suppressed zeros and emitted digits always add up to
// the full digit count, so the time does not depend on the length of the
// number.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sida_in_if.sink    in_chan,
  sida_out_if.source out_chan
);

  sida_pkg::cmd_t cmd;
  sida_pkg::sts_t sts;

  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sida_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_chan.value),
    .out_ready      (out_chan.ready),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_chan.valid),
    .out_ascii_char (out_chan.ascii_char),
    .out_last       (out_chan.last)
  );

`ifndef ASSERT_OFF
  // one number at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while a number is in work");

  // a character is only loaded when the output register has room
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
    else $error("output register overwritten");

  // the flagged final character is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last) |-> (out_chan.ascii_char != sida_pkg::CHAR_MINUS))
    else $error("last flag on sign character");

  // emitting the final digit returns the block to idle
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.one_left) |=> in_chan.ready)
    else $error("not idle after final digit");
`endif

endmodule
